### rtl/core/smf_pkg.sv
package smf_pkg;

    localparam int SAMPLE_W = 32;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pos_x;
        logic signed [SAMPLE_W-1:0] pos_y;
        logic signed [SAMPLE_W-1:0] pos_z;
    } t_smf_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_x;
        logic signed [SAMPLE_W-1:0] out_y;
        logic signed [SAMPLE_W-1:0] out_z;
        logic                       window_full;
    } t_smf_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_SCAN,
        S_TAIL,
        S_EVAL,
        S_DONE
    } t_smf_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // write the sample to the ring, hold a copy, clear ranks
        logic cand_rd;   // read data of the next cycle is the candidate
        logic cmp;       // read data of the next cycle is compared with the candidate
        logic lt;        // compared entry sits below the candidate in the ring
        logic eval;      // ranks are final: pick the candidate at the median rank
        logic load_out;  // load the output register
        logic pass;      // pass the sample through instead of the medians
    } t_smf_cmd;

    // Index width for a store of the given depth, at least one bit
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // One step of rank counting with ties broken by ring position
    function automatic logic rank_step(
        input logic signed [SAMPLE_W-1:0] entry,
        input logic signed [SAMPLE_W-1:0] cand,
        input logic                       lower_pos
    );
        return (entry < cand) || ((entry == cand) && lower_pos);
    endfunction

endpackage

### rtl/core/sliding_median_filter_3axis.sv
// While the window fills, each input beat is passed straight through to the output
//   register; once it is full, the medians come from rank counting through the single
//   read port of the history RAM. The input stalls from the taking of a beat until its
//   result is loaded into the output register, so one beat is worked on at a time.
// Reset (synchronous, active low) clears the FSM, write slot, fill count and output
//   valid; the history RAM is not cleared, since every entry is written before it is read.
module sliding_median_filter_3axis #(
    parameter int WINDOW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  smf_pkg::t_smf_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output smf_pkg::t_smf_out o_out_data
);
    import smf_pkg::*;

    localparam int AW = addr_w(WINDOW);

    // Command and status between the controller and the datapath
    t_smf_cmd      w_cmd;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic          w_out_free;

    // The controller owns the ring write slot and the fill count. For each
    // candidate entry it reads the candidate, then sweeps every entry of the
    // ring through the RAM read port so the datapath can count, per axis,
    // how many entries rank below it (ties broken by ring position). The
    // candidate whose rank equals WINDOW/2 is the median of that axis.
    smf_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd),
        .o_waddr    (w_waddr),
        .o_raddr    (w_raddr)
    );

    // The datapath holds the history RAM, the candidate, the three rank
    // counters, the selected medians and the output register. The output
    // register decouples the sides: a new input beat is taken while a
    // finished result still waits downstream.
    smf_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_waddr     (w_waddr),
        .i_raddr     (w_raddr),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/smf_ram.sv
module smf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 5,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/smf_ctrl.sv
module smf_ctrl #(
    parameter int WINDOW = 5,
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_free,
    output smf_pkg::t_smf_cmd o_cmd,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_raddr
);
    import smf_pkg::*;

    localparam int FW = $clog2(WINDOW + 1);

    t_smf_state r_state, n_state;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_slot, n_slot;
    logic [FW-1:0] r_fill, n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_slot  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_slot  <= n_slot;
            r_fill  <= n_fill;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_slot  = r_slot;
        n_fill  = r_fill;
        o_cmd   = '0;
        o_raddr = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_slot = (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (r_fill != FW'(WINDOW)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (r_fill >= FW'(WINDOW - 1)) begin
                        n_i     = '0;
                        n_state = S_CAND;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CAND: begin
                o_raddr       = r_i;
                o_cmd.cand_rd = 1'b1;
                n_j           = '0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.cmp = 1'b1;
                o_cmd.lt  = (r_j < r_i);
                if (r_j == AW'(WINDOW - 1)) begin
                    n_state = S_TAIL;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (r_i == AW'(WINDOW - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CAND;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.pass     = (r_fill != FW'(WINDOW));
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_waddr    = r_slot;

    a_fill_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && r_fill < FW'(WINDOW - 1)) |=> r_state == S_DONE)
        else $error("partial window did not go straight to output");

    a_last_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_i == AW'(WINDOW - 1)) |=> r_state == S_DONE)
        else $error("ranking ran past the last candidate");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE && r_fill != '0))
        else $error("output load did not return to idle");

endmodule

### rtl/core/smf_datapath.sv
module smf_datapath #(
    parameter int WINDOW = 5,
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smf_pkg::t_smf_cmd i_cmd,
    input  logic [AW-1:0]     i_waddr,
    input  logic [AW-1:0]     i_raddr,
    input  smf_pkg::t_smf_in  i_in_data,
    input  logic              i_out_stall,
    output logic              o_out_free,
    output logic              o_out_valid,
    output smf_pkg::t_smf_out o_out_data
);
    import smf_pkg::*;

    localparam int RW = addr_w(WINDOW);
    localparam int K  = WINDOW / 2;
    localparam int DW = $bits(t_smf_in);

    logic [DW-1:0] w_rdata;
    t_smf_in       w_rd;
    t_smf_in       r_in;
    t_smf_in       r_cand;
    t_smf_in       r_med;
    logic          r_cap_pend;
    logic          r_cmp_pend;
    logic          r_lt;
    logic [RW-1:0] r_rank_x, r_rank_y, r_rank_z;
    t_smf_out      r_out;
    logic          r_out_valid;

    smf_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_in),
        .i_waddr (i_waddr),
        .i_wdata (DW'(i_in_data)),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_smf_in'(w_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_pend  <= 1'b0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_pend <= i_cmd.cand_rd;
            r_cmp_pend <= i_cmd.cmp;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lt <= i_cmd.lt;
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (r_cap_pend) begin
            r_cand <= w_rd;
        end
        // count entries ranked below the candidate, per axis
        if (i_cmd.load_in || i_cmd.eval) begin
            r_rank_x <= '0;
            r_rank_y <= '0;
            r_rank_z <= '0;
        end else if (r_cmp_pend) begin
            r_rank_x <= r_rank_x + RW'(rank_step(w_rd.pos_x, r_cand.pos_x, r_lt));
            r_rank_y <= r_rank_y + RW'(rank_step(w_rd.pos_y, r_cand.pos_y, r_lt));
            r_rank_z <= r_rank_z + RW'(rank_step(w_rd.pos_z, r_cand.pos_z, r_lt));
        end
        if (i_cmd.eval) begin
            if (r_rank_x == RW'(K)) r_med.pos_x <= r_cand.pos_x;
            if (r_rank_y == RW'(K)) r_med.pos_y <= r_cand.pos_y;
            if (r_rank_z == RW'(K)) r_med.pos_z <= r_cand.pos_z;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.pass) begin
                r_out <= '{out_x: r_in.pos_x, out_y: r_in.pos_y, out_z: r_in.pos_z,
                           window_full: 1'b0};
            end else begin
                r_out <= '{out_x: r_med.pos_x, out_y: r_med.pos_y, out_z: r_med.pos_z,
                           window_full: 1'b1};
            end
        end
    end

    assign o_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_out && r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

    a_eval_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (!r_cmp_pend && !r_cap_pend))
        else $error("median picked before the compare pipe drained");

endmodule

### sim/smf_median_checker.sv
module smf_median_checker #(
    parameter int WINDOW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  smf_pkg::t_smf_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  smf_pkg::t_smf_out i_out_data,
    output int                o_mismatch_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    typedef logic [WINDOW-1:0][SAMPLE_W-1:0] t_axis_window;

    t_axis_window x_win;
    t_axis_window y_win;
    t_axis_window z_win;
    int unsigned  wr_slot;
    int unsigned  held;
    int unsigned  result_beats;
    t_smf_out     expected_results [$];

    // Insertion sort on a copy, signed order, take the middle rank
    function automatic logic [SAMPLE_W-1:0] window_median(input t_axis_window w);
        logic [SAMPLE_W-1:0] v;
        int                  j;
        for (int i = 1; i < WINDOW; i++) begin
            v = w[i];
            j = i;
            while (j > 0 && $signed(w[j-1]) > $signed(v)) begin
                w[j] = w[j-1];
                j--;
            end
            w[j] = v;
        end
        return w[WINDOW/2];
    endfunction

    task automatic absorb_sample(input t_smf_in s);
        t_smf_out want;
        x_win[wr_slot] = s.pos_x;
        y_win[wr_slot] = s.pos_y;
        z_win[wr_slot] = s.pos_z;
        wr_slot = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
        if (held < WINDOW) held++;
        if (held < WINDOW) begin
            want.out_x       = s.pos_x;
            want.out_y       = s.pos_y;
            want.out_z       = s.pos_z;
            want.window_full = 1'b0;
        end else begin
            want.out_x       = window_median(x_win);
            want.out_y       = window_median(y_win);
            want.out_z       = window_median(z_win);
            want.window_full = 1'b1;
        end
        expected_results.insert(expected_results.size(), want);
    endtask

    task automatic flag(input string field, input logic signed [SAMPLE_W-1:0] want,
                        input logic signed [SAMPLE_W-1:0] got);
        $display("%0t: result beat %0d %s mismatch, expected %0d, got %0d",
                 $time, result_beats, field, want, got);
        o_mismatch_count++;
    endtask

    task automatic check_result(input t_smf_out got);
        t_smf_out want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, x %0d y %0d z %0d full %0b",
                     $time, got.out_x, got.out_y, got.out_z, got.window_full);
            o_mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.out_x !== want.out_x) flag("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y) flag("out_y", want.out_y, got.out_y);
            if (got.out_z !== want.out_z) flag("out_z", want.out_z, got.out_z);
            if (got.window_full !== want.window_full)
                flag("window_full", SAMPLE_W'(want.window_full),
                     SAMPLE_W'(got.window_full));
        end
        result_beats++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_slot = 0;
            held = 0;
            result_beats = 0;
            o_mismatch_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) absorb_sample(i_in_data);
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
        end
        o_pending = expected_results.size();
    end

endmodule

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    localparam int WINDOW           = 5;
    // Full-window latency per beat, as the rank counting in the block gives it
    localparam int BLOCK_LAT        = WINDOW * (WINDOW + 3) + 2;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int HOLD_CYCLES      = 400;
    // Watchdog limit, well above the slowest legal run
    localparam int CYCLE_LIMIT      = 600000;

    localparam logic [SAMPLE_W-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] MINV = 32'h8000_0000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_smf_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_smf_out o_out_data;

    int mismatches;
    int pending;
    int idle_pct;
    int stall_pct;
    int hold_requests;
    int holds_done;
    int cycles;
    int sent;

    // Pool of recently used values, reused to force rank ties
    logic [SAMPLE_W-1:0] recent_vals [8];

    sliding_median_filter_3axis #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    smf_median_checker #(
        .WINDOW(WINDOW)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_data       (i_in_data),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_data      (o_out_data),
        .o_mismatch_count(mismatches),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a lost result ends here
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
        $display("FAIL sliding_median_filter_3axis");
        $finish;
    end

    // Receiver: random stall at the current rate, or a long hold-off on request.
    // The hold-off is counted here so the sender keeps offering beats meanwhile.
    initial begin : receiver
        i_out_stall = 1'b0;
        holds_done  = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_smf_in mk(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                                   input logic [SAMPLE_W-1:0] z);
        t_smf_in s;
        s.pos_x = x;
        s.pos_y = y;
        s.pos_z = z;
        return s;
    endfunction

    // Mix full-range noise, small values, extremes, repeats and near neighbors
    function automatic logic [SAMPLE_W-1:0] pick_value();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(9)) inside
            [0:2]: v = $urandom;
            [3:4]: v = $urandom_range(64) - 32;
            5: begin
                case ($urandom_range(5))
                    0:       v = MINV;
                    1:       v = MAXV;
                    2:       v = '0;
                    3:       v = '1;
                    4:       v = MINV + 1;
                    default: v = MAXV - 1;
                endcase
            end
            [6:7]:   v = recent_vals[$urandom_range(7)];
            default: v = recent_vals[$urandom_range(7)] + $urandom_range(4) - 2;
        endcase
        recent_vals[$urandom_range(7)] = v;
        return v;
    endfunction

    // Offer one beat, called at a falling edge. Insert idle cycles at the
    // current rate, then hold the payload until the block takes it.
    task automatic send_sample(input t_smf_in s);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent++;
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        sent          = 0;
        foreach (recent_vals[k]) recent_vals[k] = '0;

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Window filling: the first beats pass straight through, extremes included
        send_sample(mk(MAXV, MINV, '0));
        send_sample(mk(MINV, MAXV, '1));
        send_sample(mk('0, '1, MAXV));
        send_sample(mk('1, 32'd1, MINV));
        // This beat completes the window: first medians, extremes in every axis
        send_sample(mk(32'd1, '0, MINV + 1));

        // Runs of one value per axis: by the last beat of the run, every rank comparison is a tie
        for (int k = 0; k < WINDOW; k++) send_sample(mk(32'd7, MINV, MAXV));

        // Alternating bit patterns and near-extremes toggle every input bit
        send_sample(mk(32'hAAAA_AAAA, 32'h5555_5555, MAXV - 1));
        send_sample(mk(32'h5555_5555, 32'hAAAA_AAAA, MINV + 1));

        // Monotonic runs, rising in some axes and falling in others, with signs crossing zero
        for (int k = 0; k < WINDOW; k++)
            send_sample(mk(100 - 10 * k, -k, k * k - 3));
        for (int k = 0; k < WINDOW; k++)
            send_sample(mk(-50 + 25 * k, 32'h8000_0010 + k, 3 - k));
        drain();

        // Random phases: no idling, sparse sender, stalling receiver, then both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 81;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 81;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            // Long receiver hold-off while beats keep coming: back-pressure
            // must reach the input side
            if (ph == 0) hold_requests++;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Pause mid-phase until the block has emptied out
                if (ph == 1 && n == RANDOM_PER_PHASE / 2) drain();
                send_sample(mk(pick_value(), pick_value(), pick_value()));
            end
            drain();
        end

        // Let any stray beat show up before the verdict
        repeat (2 * BLOCK_LAT) @(negedge i_clk);

        $display("Sent %0d samples: fill, ties, extremes, monotonic runs, then random",
                 sent);
        $display("Random mixes ran free, sender-idle, receiver-stall and both, %s%0d cycles",
                 "with a hold-off of ", HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASS sliding_median_filter_3axis");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL sliding_median_filter_3axis");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/smf_pkg.sv
rtl/core/smf_ram.sv
rtl/core/smf_ctrl.sv
rtl/core/smf_datapath.sv
rtl/core/sliding_median_filter_3axis.sv
sim/smf_median_checker.sv
sim/tb_top.sv
